@@ rtl/mtfm_pkg.sv @@
// Package for the multi-token first-match search unit: constants, config indexes, match types.
`timescale 1ns / 1ps

package mtfm_pkg;

    localparam int MAX_TOKENS    = 4;
    localparam int MAX_TOKEN_LEN = 8;
    localparam int POSITION_BITS = 16;
    localparam int WIN_DEPTH     = 8;
    localparam int TOK_W         = 2;
    localparam int LEN_W         = 4;
    localparam int CNT_W         = 3;
    localparam int BYTES_W       = 8 * MAX_TOKEN_LEN;
    localparam int PCNT_W        = POSITION_BITS + 1;

    typedef logic [7:0]               byte_t;
    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [PCNT_W-1:0]        pcnt_t;

    // Best match seen so far in the current string
    typedef struct packed {
        logic             found;
        pos_t             pos;
        logic [TOK_W-1:0] tok;
    } best_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_FROM_INDEX    = 3'd0;
    localparam logic [2:0] CFG_TO_INDEX      = 3'd1;
    localparam logic [2:0] CFG_TOKEN_COUNT   = 3'd2;
    localparam logic [2:0] CFG_TOKEN_LENGTHS = 3'd3;
    localparam logic [2:0] CFG_TOKEN_BYTES_A = 3'd4;
    localparam logic [2:0] CFG_TOKEN_BYTES_B = 3'd5;
    localparam logic [2:0] CFG_TOKEN_BYTES_C = 3'd6;
    localparam logic [2:0] CFG_TOKEN_BYTES_D = 3'd7;

endpackage

@@ rtl/mtfm_match.sv @@
// Parallel token compare over the byte window and best-match update for one byte.
`timescale 1ns / 1ps

module mtfm_match (
    input  mtfm_pkg::byte_t                    win_byte [mtfm_pkg::WIN_DEPTH],
    input  logic [mtfm_pkg::WIN_DEPTH-1:0]     win_ok,
    input  mtfm_pkg::pos_t                     q,
    input  logic                               ok,
    input  logic [mtfm_pkg::CNT_W-1:0]         token_count,
    input  logic [mtfm_pkg::LEN_W*mtfm_pkg::MAX_TOKENS-1:0] token_lengths,
    input  logic [mtfm_pkg::BYTES_W-1:0]       token_bytes [mtfm_pkg::MAX_TOKENS],
    input  mtfm_pkg::best_t                    best_cur,
    output mtfm_pkg::best_t                    best_next
);

    always_comb begin
        logic [mtfm_pkg::CNT_W-1:0]     count;
        logic [mtfm_pkg::LEN_W-1:0]     nib;
        logic [mtfm_pkg::LEN_W-1:0]     len;
        logic [2:0]                     len_m1;
        logic [mtfm_pkg::WIN_DEPTH-1:0] hit_by_len;
        logic                           hit;
        mtfm_pkg::pos_t                 pos;
        mtfm_pkg::best_t                cur;

        count = (token_count > mtfm_pkg::CNT_W'(mtfm_pkg::MAX_TOKENS)) ?
                mtfm_pkg::CNT_W'(mtfm_pkg::MAX_TOKENS) : token_count;
        cur = best_cur;
        for (int t = 0; t < mtfm_pkg::MAX_TOKENS; t++) begin
            nib = token_lengths[mtfm_pkg::LEN_W*t +: mtfm_pkg::LEN_W];
            len = (nib > mtfm_pkg::LEN_W'(mtfm_pkg::MAX_TOKEN_LEN)) ?
                  mtfm_pkg::LEN_W'(mtfm_pkg::MAX_TOKEN_LEN) : nib;
            len_m1 = 3'(len - 4'd1);
            // Match for every possible length; the newest byte sits at index 0
            for (int l = 0; l < mtfm_pkg::WIN_DEPTH; l++) begin
                hit_by_len[l] = win_ok[l];
                for (int k = 0; k <= l; k++) begin
                    if (win_byte[l-k] != token_bytes[t][8*k +: 8]) begin
                        hit_by_len[l] = 1'b0;
                    end
                end
            end
            if (len == '0) begin
                hit = ok;
                pos = q;
            end else begin
                hit = hit_by_len[len_m1];
                pos = q - mtfm_pkg::POSITION_BITS'(len_m1);
            end
            if (mtfm_pkg::CNT_W'(t) < count && hit &&
                (!cur.found || pos < cur.pos ||
                 (pos == cur.pos && mtfm_pkg::TOK_W'(t) < cur.tok))) begin
                cur.found = 1'b1;
                cur.pos   = pos;
                cur.tok   = mtfm_pkg::TOK_W'(t);
            end
        end
        best_next = cur;
    end

endmodule

@@ rtl/multi_token_first_match_search_unit.sv @@
// Top level of the multi-token first-match search unit over a streamed byte string.
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// cfg      | cfg_we             | cfg_index[2:0], cfg_wdata[63:0]
// s (in)   | s_valid / s_ready  | s_src_byte[7:0], s_end_of_string
// m (out)  | m_valid / m_ready  | m_found, m_match_position[15:0], m_token_index[1:0],
//          |                    | m_too_long
//
// One request per cycle sustained unless an end-of-string byte waits for room:
// a byte lands in the input register, then window shift, token compare and
// best-match update. The output register loads as the end-of-string byte moves on.
// Reset (aresetn low, synchronous) clears configuration, string state and both
// valid flags. A full output register stalls only an end-of-string byte.

module multi_token_first_match_search_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [63:0]                     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_src_byte,
    input  logic                            s_end_of_string,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [15:0]                     m_match_position,
    output logic [1:0]                      m_token_index,
    output logic                            m_too_long
);

    localparam int WD = mtfm_pkg::WIN_DEPTH;
    localparam int PB = mtfm_pkg::POSITION_BITS;

    // Configuration registers
    logic [15:0]                 from_reg;
    logic [15:0]                 to_reg;
    logic [mtfm_pkg::CNT_W-1:0]  count_reg;
    logic [15:0]                 lengths_reg;
    logic [mtfm_pkg::BYTES_W-1:0] tok_bytes_reg [mtfm_pkg::MAX_TOKENS];

    // Input register
    logic            in_valid_reg, in_valid_next;
    mtfm_pkg::byte_t in_byte_reg;
    logic            in_eos_reg;

    // Per-string state
    mtfm_pkg::byte_t win_byte_reg  [WD];
    mtfm_pkg::byte_t win_byte_next [WD];
    logic [WD-1:0]   win_ok_reg, win_ok_next, win_ok_shift;
    mtfm_pkg::pcnt_t pos_reg, pos_next;
    mtfm_pkg::pcnt_t next_start_reg, next_start_next;
    mtfm_pkg::best_t best_reg, best_next, best_step;
    logic            overflow_reg, overflow_next;

    // Output register
    logic            m_valid_reg, m_valid_next;
    mtfm_pkg::best_t out_best_reg;
    logic            out_too_long_reg;

    logic            advance;
    logic            load_out;
    logic            over;
    logic            cand;
    logic            ok;
    logic            lead;
    mtfm_pkg::pcnt_t from_ext;
    mtfm_pkg::pcnt_t to_ext;

    // Take a new byte when the input register empties or moves on this cycle;
    // an end-of-string byte waits for room in the output register.
    assign advance  = in_valid_reg && (!in_eos_reg || !m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign load_out = advance && in_eos_reg;

    assign from_ext = mtfm_pkg::PCNT_W'(from_reg);
    assign to_ext   = mtfm_pkg::PCNT_W'(to_reg);
    assign over     = pos_reg[PB];

    // A candidate is the first position or the next character boundary past it
    assign cand = (pos_reg == from_ext) || (pos_reg > from_ext && pos_reg == next_start_reg);
    assign ok   = cand && (pos_reg < to_ext);
    // Shift-JIS lead byte: the character takes two bytes
    assign lead = (in_byte_reg >= 8'h81 && in_byte_reg <= 8'h9F) ||
                  (in_byte_reg >= 8'hE0 && in_byte_reg <= 8'hFC);

    // Window after this byte goes in; index 0 holds the newest byte
    always_comb begin
        win_byte_next[0] = in_byte_reg;
        for (int i = 1; i < WD; i++) begin
            win_byte_next[i] = win_byte_reg[i-1];
        end
        win_ok_shift = {win_ok_reg[WD-2:0], ok};
    end

    mtfm_match u_match (
        .win_byte      (win_byte_next),
        .win_ok        (win_ok_shift),
        .q             (pos_reg[PB-1:0]),
        .ok            (ok),
        .token_count   (count_reg),
        .token_lengths (lengths_reg),
        .token_bytes   (tok_bytes_reg),
        .best_cur      (best_reg),
        .best_next     (best_step)
    );

    // Next string state
    always_comb begin
        in_valid_next   = s_valid && s_ready ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        win_ok_next     = win_ok_reg;
        pos_next        = pos_reg;
        next_start_next = next_start_reg;
        best_next       = best_reg;
        overflow_next   = overflow_reg;
        if (advance) begin
            if (in_eos_reg) begin
                // Close the string: clear everything for the next one
                win_ok_next     = '0;
                pos_next        = '0;
                next_start_next = '0;
                best_next       = '0;
                overflow_next   = 1'b0;
            end else if (over) begin
                // Past the position limit: drop the byte, flag it
                overflow_next = 1'b1;
            end else begin
                win_ok_next = win_ok_shift;
                pos_next    = pos_reg + mtfm_pkg::PCNT_W'(1);
                best_next   = best_step;
                if (cand) begin
                    next_start_next = pos_reg + (lead ? mtfm_pkg::PCNT_W'(2) :
                                                        mtfm_pkg::PCNT_W'(1));
                end
            end
        end
    end

    // Output valid: set on a closed string, clear when taken
    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            from_reg       <= '0;
            to_reg         <= '0;
            count_reg      <= '0;
            lengths_reg    <= '0;
            for (int t = 0; t < mtfm_pkg::MAX_TOKENS; t++) begin
                tok_bytes_reg[t] <= '0;
            end
            in_valid_reg   <= 1'b0;
            win_ok_reg     <= '0;
            pos_reg        <= '0;
            next_start_reg <= '0;
            best_reg       <= '0;
            overflow_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mtfm_pkg::CFG_FROM_INDEX:    from_reg    <= cfg_wdata[15:0];
                    mtfm_pkg::CFG_TO_INDEX:      to_reg      <= cfg_wdata[15:0];
                    mtfm_pkg::CFG_TOKEN_COUNT:   count_reg   <= cfg_wdata[mtfm_pkg::CNT_W-1:0];
                    mtfm_pkg::CFG_TOKEN_LENGTHS: lengths_reg <= cfg_wdata[15:0];
                    mtfm_pkg::CFG_TOKEN_BYTES_A: tok_bytes_reg[0] <= cfg_wdata;
                    mtfm_pkg::CFG_TOKEN_BYTES_B: tok_bytes_reg[1] <= cfg_wdata;
                    mtfm_pkg::CFG_TOKEN_BYTES_C: tok_bytes_reg[2] <= cfg_wdata;
                    mtfm_pkg::CFG_TOKEN_BYTES_D: tok_bytes_reg[3] <= cfg_wdata;
                    default: ;
                endcase
            end
            in_valid_reg   <= in_valid_next;
            win_ok_reg     <= win_ok_next;
            pos_reg        <= pos_next;
            next_start_reg <= next_start_next;
            best_reg       <= best_next;
            overflow_reg   <= overflow_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_src_byte;
            in_eos_reg  <= s_end_of_string;
        end
        if (advance && !in_eos_reg && !over) begin
            for (int i = 0; i < WD; i++) begin
                win_byte_reg[i] <= win_byte_next[i];
            end
        end
        if (load_out) begin
            // A dropped closing byte leaves the best match as it was
            out_best_reg     <= over ? best_reg : best_step;
            out_too_long_reg <= over || overflow_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found          = out_best_reg.found;
    assign m_match_position = 16'(out_best_reg.pos);
    assign m_token_index    = out_best_reg.tok;
    assign m_too_long       = out_too_long_reg;

endmodule
